### src/icdf_pkg.sv
`timescale 1ns / 1ps

package icdf_pkg;

  // Table geometry and fixed point format.
  localparam int TABLE_DEPTH   = 1024;
  localparam int FRACTION_BITS = 24;
  localparam int VAL_W         = FRACTION_BITS + 1;
  localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int PROD_W        = 2 * VAL_W;

  localparam logic [VAL_W-1:0] FX_ONE     = VAL_W'(1) << FRACTION_BITS;
  localparam logic [VAL_W-1:0] FX_MASK    = {VAL_W{1'b1}};
  localparam logic [VAL_W-1:0] STEP_RESET = VAL_W'(16777);

  localparam logic [CNT_W-1:0] LAST_ENTRY = CNT_W'(TABLE_DEPTH - 1);

  // Input command codes.
  localparam logic CMD_BUILD  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;      // capture the accepted item and initialize
    logic build_mul;  // form 2*y*step
    logic build_acc;  // accumulate, advance y, store one table entry
    logic srch_cmp;   // narrow the search window
    logic load_out;   // load the result register
  } icdf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic y_done;       // next grid point reaches one
    logic full;         // the entry being written is the last one
    logic search_more;  // search window is not empty
    logic out_free;     // result register can take a new result
  } icdf_stat_t;

endpackage

### src/icdf_ctrl.sv
`timescale 1ns / 1ps

module icdf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 command,
  output logic                 in_stall,
  input  icdf_pkg::icdf_stat_t stat,
  output icdf_pkg::icdf_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_B_MUL  = 3'd1;
  localparam logic [2:0] ST_B_ACC  = 3'd2;
  localparam logic [2:0] ST_S_RD   = 3'd3;
  localparam logic [2:0] ST_S_CMP  = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = (command == icdf_pkg::CMD_SAMPLE) ? ST_S_RD : ST_B_MUL;
        end
      end
      ST_B_MUL: begin
        cmd.build_mul = 1'b1;
        state_next    = ST_B_ACC;
      end
      ST_B_ACC: begin
        cmd.build_acc = 1'b1;
        state_next    = (stat.y_done || stat.full) ? ST_FIN : ST_B_MUL;
      end
      ST_S_RD: begin
        // The datapath reads the table at the window midpoint, or the grid
        // entry at the window start once the window has closed.
        state_next = stat.search_more ? ST_S_CMP : ST_FIN;
      end
      ST_S_CMP: begin
        cmd.srch_cmp = 1'b1;
        state_next   = ST_S_RD;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/icdf_dp.sv
`timescale 1ns / 1ps

module icdf_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_enable,
  input  logic [icdf_pkg::VAL_W-1:0]           cfg_write_data,
  input  logic                                 command,
  input  logic [icdf_pkg::FRACTION_BITS-1:0]   uniform_value,
  input  icdf_pkg::icdf_cmd_t                  cmd,
  output icdf_pkg::icdf_stat_t                 stat,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [icdf_pkg::VAL_W-1:0]           sample_value,
  output logic [icdf_pkg::CNT_W-1:0]           entry_total,
  output logic                                 status
);

  localparam int VW = icdf_pkg::VAL_W;
  localparam int CW = icdf_pkg::CNT_W;
  localparam int AW = icdf_pkg::ADDR_W;
  localparam int PW = icdf_pkg::PROD_W;
  localparam int FB = icdf_pkg::FRACTION_BITS;

  logic [VW-1:0] cum_mem  [icdf_pkg::TABLE_DEPTH];
  logic [VW-1:0] grid_mem [icdf_pkg::TABLE_DEPTH];

  logic [VW-1:0] step;
  logic [VW-1:0] y;
  logic [VW-1:0] acc;
  logic [PW-1:0] prod;
  logic [CW-1:0] entries;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] mid;
  logic [FB-1:0] k;
  logic          is_sample;
  logic          trunc_flag;
  logic [VW-1:0] rd_cum;
  logic [VW-1:0] rd_grid;

  logic [VW-1:0] step_eff;
  logic [VW-1:0] y_next;
  logic [VW-1:0] acc_next;
  logic [VW+1:0] acc_sum;
  logic [CW-1:0] mid_next;
  logic [CW-1:0] span;

  // A zero step behaves as the smallest step.
  assign step_eff = (step == '0) ? VW'(1) : step;

  assign stat.y_done      = (step_eff >= (icdf_pkg::FX_ONE - y));
  assign stat.full        = (entries == icdf_pkg::LAST_ENTRY);
  assign stat.search_more = (lo < hi);
  assign stat.out_free    = !out_valid || !out_stall;

  assign y_next   = stat.y_done ? icdf_pkg::FX_ONE : y + step_eff;
  assign acc_sum  = (VW + 2)'(acc) + (VW + 2)'(prod[PW-1:FB]);
  assign acc_next = (acc_sum > (VW + 2)'(icdf_pkg::FX_MASK)) ? icdf_pkg::FX_MASK
                                                             : acc_sum[VW-1:0];
  assign span     = hi - lo;
  assign mid_next = lo + (span >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= icdf_pkg::STEP_RESET;
    end else if (cfg_write_enable) begin
      step <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_acc) begin
      cum_mem[entries[AW-1:0]] <= acc_next;
    end
    rd_cum <= cum_mem[mid_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.build_acc) begin
      grid_mem[entries[AW-1:0]] <= y_next;
    end
    rd_grid <= grid_mem[lo[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= '0;
    end else if (cmd.start && (command == icdf_pkg::CMD_BUILD)) begin
      entries <= '0;
    end else if (cmd.build_acc) begin
      entries <= entries + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      k          <= uniform_value;
      is_sample  <= (command == icdf_pkg::CMD_SAMPLE);
      y          <= '0;
      acc        <= '0;
      trunc_flag <= 1'b0;
      lo         <= '0;
      hi         <= entries;
    end
    if (cmd.build_mul) begin
      prod <= PW'({y[VW-2:0], 1'b0}) * PW'(step_eff);
    end
    if (cmd.build_acc) begin
      acc        <= acc_next;
      y          <= y_next;
      trunc_flag <= !stat.y_done && stat.full;
    end
    mid <= mid_next;
    if (cmd.srch_cmp) begin
      if (rd_cum < VW'(k)) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      entry_total <= entries;
      if (is_sample) begin
        sample_value <= (lo >= entries) ? icdf_pkg::FX_ONE : rd_grid;
        status       <= 1'b0;
      end else begin
        sample_value <= '0;
        status       <= trunc_flag;
      end
    end
  end

endmodule

### src/inverse_cdf_table_sampler.sv
`timescale 1ns / 1ps

// Inverse-transform sampler for the density 2y on [0,1], all values unsigned
// fixed point with 24 fraction bits. A build item (command 0) walks the grid
// from zero in steps of integration_step, accumulating the truncated product
// 2*y*step into a saturating cumulative probability and storing one
// (cumulative, grid) pair per point in two 1024-entry RAMs; each entry goes
// through a registered multiply step and then an accumulate-and-write step,
// and the result load and the accepting idle state come on top. A build that
// would need more than 1024 entries keeps the first 1024 and reports status 1.
// A sample item (command 1) binary-searches the cumulative table for the first
// entry at or above uniform_value and returns its grid value, or 1.0 when no
// entry qualifies; each search step is one RAM read followed by one compare.
// One item is worked on at a time; the result register lets the next item be
// accepted while a finished result still waits on out_stall. Every item
// yields exactly one result item. The user must write integration_step
// through cfg_write_enable and cfg_write_data only while the block is idle;
// the block itself does not enforce this.

module inverse_cdf_table_sampler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write_enable,
  input  logic [icdf_pkg::VAL_W-1:0]         cfg_write_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               command,
  input  logic [icdf_pkg::FRACTION_BITS-1:0] uniform_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [icdf_pkg::VAL_W-1:0]         sample_value,
  output logic [icdf_pkg::CNT_W-1:0]         entry_total,
  output logic                               status
);

  icdf_pkg::icdf_cmd_t  cmd;
  icdf_pkg::icdf_stat_t stat;

  // The controller sequences build and search steps; it only accepts an item
  // while idle.
  icdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the step register, the two table RAMs, the multiplier,
  // the accumulator, the search window and the result register.
  icdf_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .command          (command),
    .uniform_value    (uniform_value),
    .cmd              (cmd),
    .stat             (stat),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .sample_value     (sample_value),
    .entry_total      (entry_total),
    .status           (status)
  );

endmodule

### tb/sv/icdf_result_checker.sv
`timescale 1ns / 1ps

module icdf_result_checker
  import icdf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_enable,
  input  logic [VAL_W-1:0]         cfg_write_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     command,
  input  logic [FRACTION_BITS-1:0] uniform_value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [VAL_W-1:0]         sample_value,
  input  logic [CNT_W-1:0]         entry_total,
  input  logic                     status,
  output int                       mismatch_total,
  output int                       results_owed
);

  typedef struct packed {
    logic [VAL_W-1:0] sample_value;
    logic [CNT_W-1:0] entry_total;
    logic             status;
  } sampler_result_t;

  // Mirror of the two tables, the number of valid entries and the step.
  logic [VAL_W-1:0] cdf_column  [TABLE_DEPTH];
  logic [VAL_W-1:0] grid_column [TABLE_DEPTH];
  int unsigned      entry_count;
  logic [VAL_W-1:0] step_value;

  sampler_result_t owed_q[$];
  int              mismatches;

  // Works out the result of one item and updates the mirrored tables.
  function automatic sampler_result_t sampler_response(
    input logic                     cmd,
    input logic [FRACTION_BITS-1:0] k
  );
    sampler_result_t res;
    longint unsigned one, full, step, y, acc, inc;
    int unsigned     n, lo, hi, mid;
    res  = '0;
    one  = 64'(FX_ONE);
    full = 64'(FX_MASK);
    if (cmd == CMD_BUILD) begin
      // A zero step behaves as the smallest step.
      step = (step_value == '0) ? 64'd1 : 64'(step_value);
      y    = 0;
      acc  = 0;
      n    = 0;
      while (y < one && !res.status) begin
        if (n >= TABLE_DEPTH) begin
          res.status = 1'b1;
        end else begin
          inc = ((y << 1) * step) >> FRACTION_BITS;
          acc = (inc > full - acc) ? full : acc + inc;
          y   = (step >= one - y) ? one : y + step;
          cdf_column[n]  = VAL_W'(acc);
          grid_column[n] = VAL_W'(y);
          n++;
        end
      end
      entry_count = n;
    end else begin
      lo = 0;
      hi = entry_count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (cdf_column[mid] < {1'b0, k}) begin
          lo = mid + 1;
        end else begin
          hi = mid;
        end
      end
      res.sample_value = (lo >= entry_count) ? FX_ONE : grid_column[lo];
    end
    res.entry_total = CNT_W'(entry_count);
    return res;
  endfunction

  always @(posedge clk) begin
    sampler_result_t got;
    sampler_result_t want;
    if (rst) begin
      entry_count = 0;
      step_value  = STEP_RESET;
      mismatches  = 0;
      owed_q.delete();
    end else begin
      if (cfg_write_enable) begin
        step_value = cfg_write_data;
      end
      if (out_valid && !out_stall) begin
        got = {sample_value, entry_total, status};
        if (owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing expected: value %h total %0d status %b",
                     $realtime, got.sample_value, got.entry_total, got.status);
          end
        end else begin
          want = owed_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected value %h total %0d status %b,",
                       $realtime, want.sample_value, want.entry_total, want.status,
                       " got value %h total %0d status %b",
                       got.sample_value, got.entry_total, got.status);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        owed_q.insert(owed_q.size(), sampler_response(command, uniform_value));
      end
    end
    mismatch_total <= mismatches;
    results_owed   <= owed_q.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

// Top of the sampler bench. This module only creates stimulus and gives the
// verdict; the checker beside the block mirrors the tables, predicts each
// result item and compares what comes out.
module testbench;
  import icdf_pkg::*;

  // The slowest legitimate quiet stretch is a full 1024-entry build plus a
  // receiver stall; this limit is many times that.
  localparam int QUIET_LIMIT = 20000;

  // Every block input holds a known value from time zero.
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write_enable = 1'b0;
  logic [VAL_W-1:0]         cfg_write_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     command = CMD_BUILD;
  logic [FRACTION_BITS-1:0] uniform_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [VAL_W-1:0]         sample_value;
  logic [CNT_W-1:0]         entry_total;
  logic                     status;

  int mismatch_total;
  int results_owed;
  int quiet_cycles = 0;
  int stall_left = 0;

  // Idling switches. The sender switch is used only by the stimulus process;
  // the receiver switch is changed with nonblocking writes so the receiver
  // process sees a stable value at each edge.
  logic idle_gaps = 1'b0;
  logic stall_gaps = 1'b0;

  always #1 clk = ~clk;

  inverse_cdf_table_sampler dut (.*);

  icdf_result_checker result_check (.*);

  // Receiver: after each accepted result item it draws how many cycles of
  // pending output it holds off the next one. The countdown only runs while
  // out_valid is high, so stalls land on results rather than on empty cycles.
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        stall_left = stall_gaps ? $urandom_range(0, 7) : 0;
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // Watchdog: ends the run if no item moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one item and returns at the edge where it is taken. When no gap
  // is drawn, in_valid simply stays high for the next item, so it never gets
  // two writes in one time step.
  task automatic send_item(input logic cmd, input logic [FRACTION_BITS-1:0] k);
    int gap;
    gap = idle_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    uniform_value <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops sending and waits until every expected result item has come back.
  // The owed count from the checker is registered, hence the first wait.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // The step register is only written while the block has nothing in hand.
  task automatic set_step(input logic [VAL_W-1:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  initial begin
    logic                     cmd;
    logic [FRACTION_BITS-1:0] k;
    logic [VAL_W-1:0]         stp;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Sampling before any build finds no entry, so both ends answer one.
    send_item(CMD_SAMPLE, '0);
    send_item(CMD_SAMPLE, '1);

    // Build with the reset step, about a thousand entries, then probe it.
    send_item(CMD_BUILD, FRACTION_BITS'($urandom));
    send_item(CMD_SAMPLE, '0);
    send_item(CMD_SAMPLE, '1);
    send_item(CMD_SAMPLE, FRACTION_BITS'(24'h400000));

    // A zero step acts as a step of one, fills the table and flags overflow.
    idle_gaps = 1'b1;
    set_step('0);
    send_item(CMD_BUILD, '1);
    send_item(CMD_SAMPLE, FRACTION_BITS'(1));
    send_item(CMD_SAMPLE, '1);

    // A step of 1/1024 fills the table exactly and is not an overflow, while
    // one count less needs one more entry than the table holds.
    stall_gaps <= 1'b1;
    set_step(VAL_W'(16384));
    send_item(CMD_BUILD, '0);
    send_item(CMD_SAMPLE, FRACTION_BITS'(24'h800000));
    set_step(VAL_W'(16383));
    send_item(CMD_BUILD, '0);
    send_item(CMD_SAMPLE, FRACTION_BITS'(24'h3FFFFF));

    // Steps of one and above clamp the first point to one: a single entry.
    set_step(FX_MASK);
    send_item(CMD_BUILD, '0);
    send_item(CMD_SAMPLE, '0);
    send_item(CMD_SAMPLE, FRACTION_BITS'(1));
    set_step(FX_ONE);
    send_item(CMD_BUILD, '1);
    send_item(CMD_SAMPLE, '1);

    // With a step of one half the second cumulative value is exactly one half,
    // so a draw equal to it must pick that entry.
    set_step(FX_ONE >> 1);
    send_item(CMD_BUILD, '0);
    send_item(CMD_SAMPLE, FRACTION_BITS'(24'h800000));
    send_item(CMD_SAMPLE, '0);

    // A quarter step gives cumulative values 0, 1/8, 3/8 and 3/4: draws on and
    // just past a boundary, and past the last entry.
    set_step(FX_ONE >> 2);
    send_item(CMD_BUILD, '0);
    send_item(CMD_SAMPLE, FRACTION_BITS'(24'h200000));
    send_item(CMD_SAMPLE, FRACTION_BITS'(24'h200001));
    send_item(CMD_SAMPLE, FRACTION_BITS'(24'hC00000));
    send_item(CMD_SAMPLE, FRACTION_BITS'(24'hC00001));

    // Random part: twenty runs of a hundred items, each under its own step.
    // Most steps are coarse so builds stay short; a few fill the table.
    for (int run = 0; run < 20; run++) begin
      case ($urandom_range(0, 9))
        0:       stp = VAL_W'($urandom_range(0, 16383));
        1:       stp = VAL_W'($urandom_range(16384, 262143));
        9:       stp = VAL_W'($urandom_range(FX_ONE, FX_MASK));
        default: stp = VAL_W'($urandom_range(262144, FX_ONE));
      endcase
      set_step(stp);
      idle_gaps = ($urandom_range(0, 3) != 0);
      stall_gaps <= ($urandom_range(0, 3) != 0);

      for (int i = 0; i < 100; i++) begin
        // A run usually opens with a build; later builds are occasional.
        if (i == 0) begin
          cmd = ($urandom_range(0, 3) != 0) ? CMD_BUILD : CMD_SAMPLE;
        end else begin
          cmd = ($urandom_range(0, 9) == 0) ? CMD_BUILD : CMD_SAMPLE;
        end
        // Draws spread over the full range, both ends, and powers of two.
        case ($urandom_range(0, 3))
          0:       k = FRACTION_BITS'($urandom);
          1:       k = FRACTION_BITS'($urandom_range(0, 15));
          2:       k = '1 - FRACTION_BITS'($urandom_range(0, 15));
          default: k = (FRACTION_BITS'(1) << $urandom_range(0, FRACTION_BITS - 1))
                       - FRACTION_BITS'($urandom_range(0, 1));
        endcase
        send_item(cmd, k);
      end
    end

    // Let the last result items arrive, then allow for a full search.
    drain();
    repeat (40) @(posedge clk);
    if (mismatch_total == 0 && results_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
src/icdf_pkg.sv
src/icdf_ctrl.sv
src/icdf_dp.sv
src/inverse_cdf_table_sampler.sv
tb/sv/icdf_result_checker.sv
tb/sv/testbench.sv
